FILE: rtl/stki_pkg.sv
// ----------------------------------------------------------------------------
// stki_pkg
// Request and status codes, controller states and the command/status
// structs shared by the top-k table controller and datapath.
// ----------------------------------------------------------------------------
package stki_pkg;

  localparam int TAG_W    = 32;
  localparam int SCORE_W  = 32;
  localparam int REQ_W    = 3;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FIND   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_RESOLVE,
    S_APPLY
  } ctrl_state_t;

  typedef struct packed {
    logic load_req;
    logic compare;
    logic resolve;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/stki_if.sv
// ----------------------------------------------------------------------------
// stki channel interfaces
// Request, response and configuration channels of the top-k table, each a
// valid/ready channel with a source and a sink modport.
// ----------------------------------------------------------------------------
interface stki_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [31:0]        entry_tag;
  logic signed [31:0] entry_score;
  logic [3:0]         position;

  modport source (output valid, req_type, entry_tag, entry_score, position, input ready);
  modport sink   (input valid, req_type, entry_tag, entry_score, position, output ready);
endinterface

interface stki_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [3:0]         out_position;
  logic [31:0]        out_tag;
  logic signed [31:0] out_score;

  modport source (output valid, status, out_position, out_tag, out_score, input ready);
  modport sink   (input valid, status, out_position, out_tag, out_score, output ready);
endinterface

interface stki_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] empty_tag;

  modport source (output valid, empty_tag, input ready);
  modport sink   (input valid, empty_tag, output ready);
endinterface

FILE: rtl/stki_ctrl.sv
// ----------------------------------------------------------------------------
// stki_ctrl
// Sequencer for one request: capture, compare, resolve, apply.
// ----------------------------------------------------------------------------
module stki_ctrl
  import stki_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_next  = S_APPLY;
      end
      S_APPLY: begin
        // hold until the response register can take the word
        if (stat.out_free) begin
          cmd.apply  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/stki_datapath.sv
// ----------------------------------------------------------------------------
// stki_datapath
// Row of table cells with per-cell compare, priority resolve, shift update
// and the response register.
// ----------------------------------------------------------------------------
module stki_datapath
  import stki_pkg::*;
#(
  parameter int LIST_SIZE = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic [REQ_W-1:0]           in_req_type,
  input  logic [TAG_W-1:0]           in_entry_tag,
  input  logic signed [SCORE_W-1:0]  in_entry_score,
  input  logic [POS_W-1:0]           in_position,
  input  logic                       cfg_valid,
  input  logic [TAG_W-1:0]           cfg_empty_tag,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [POS_W-1:0]           out_position,
  output logic [TAG_W-1:0]           out_tag,
  output logic signed [SCORE_W-1:0]  out_score
);

  localparam int IDX_W = $clog2(LIST_SIZE);
  localparam int CNT_W = $clog2(LIST_SIZE + 1);
  localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [TAG_W-1:0]          empty_tag;
  logic [TAG_W-1:0]          tag_cell   [LIST_SIZE];
  logic signed [SCORE_W-1:0] score_cell [LIST_SIZE];

  logic [REQ_W-1:0]          req_type;
  logic [TAG_W-1:0]          req_tag;
  logic signed [SCORE_W-1:0] req_score;
  logic [POS_W-1:0]          req_pos;

  logic [LIST_SIZE-1:0] gt_flag;
  logic [LIST_SIZE-1:0] eq_flag;
  logic [IDX_W-1:0]     ins_idx;
  logic                 ins_hit;
  logic [IDX_W-1:0]     find_idx;
  logic                 find_hit;
  logic [IDX_W-1:0]     ins_idx_next;
  logic                 ins_hit_next;
  logic [IDX_W-1:0]     find_idx_next;
  logic                 find_hit_next;

  logic [PW-1:0]        pos_ext;
  logic                 pos_ok;
  logic [IDX_W-1:0]     pos_idx;
  logic [IDX_W-1:0]     rd_idx;
  logic                 do_insert;
  logic                 do_delete;
  logic                 do_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_tag <= '0;
    end else if (cfg_valid) begin
      empty_tag <= cfg_empty_tag;
    end
  end

  // capture request word
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type  <= in_req_type;
      req_tag   <= in_entry_tag;
      req_score <= in_entry_score;
      req_pos   <= in_position;
    end
  end

  // compare every cell in parallel
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < LIST_SIZE; i++) begin
        gt_flag[i] <= req_score > score_cell[i];
        eq_flag[i] <= tag_cell[i] == req_tag;
      end
    end
  end

  // first greater score for insert, last matching tag for find
  always_comb begin
    ins_idx_next  = '0;
    ins_hit_next  = 1'b0;
    find_idx_next = '0;
    find_hit_next = 1'b0;
    for (int i = LIST_SIZE - 1; i >= 0; i--) begin
      if (gt_flag[i]) begin
        ins_idx_next = IDX_W'(i);
        ins_hit_next = 1'b1;
      end
    end
    for (int i = 0; i < LIST_SIZE; i++) begin
      if (eq_flag[i]) begin
        find_idx_next = IDX_W'(i);
        find_hit_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      ins_idx  <= ins_idx_next;
      ins_hit  <= ins_hit_next;
      find_idx <= find_idx_next;
      find_hit <= find_hit_next;
    end
  end

  assign pos_ext   = PW'(req_pos);
  assign pos_ok    = pos_ext < PW'(LIST_SIZE);
  assign pos_idx   = pos_ext[IDX_W-1:0];
  assign rd_idx    = (req_type == REQ_READ) ? pos_idx : find_idx;
  assign do_insert = cmd.apply && (req_type == REQ_INSERT) && ins_hit;
  assign do_delete = cmd.apply && (req_type == REQ_DELETE) && pos_ok;
  assign do_clear  = cmd.apply && (req_type == REQ_CLEAR);

  for (genvar g = 0; g < LIST_SIZE; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (rst) begin
        tag_cell[g]   <= '0;
        score_cell[g] <= '0;
      end else if (do_clear) begin
        tag_cell[g]   <= empty_tag;
        score_cell[g] <= '0;
      end else if (do_insert) begin
        if (IDX_W'(g) == ins_idx) begin
          tag_cell[g]   <= req_tag;
          score_cell[g] <= req_score;
        end else if (g > 0 && IDX_W'(g) > ins_idx) begin
          tag_cell[g]   <= tag_cell[(g > 0) ? g - 1 : 0];
          score_cell[g] <= score_cell[(g > 0) ? g - 1 : 0];
        end
      end else if (do_delete) begin
        if (g == LIST_SIZE - 1) begin
          tag_cell[g]   <= empty_tag;
          score_cell[g] <= '0;
        end else if (IDX_W'(g) >= pos_idx) begin
          tag_cell[g]   <= tag_cell[(g < LIST_SIZE - 1) ? g + 1 : g];
          score_cell[g] <= score_cell[(g < LIST_SIZE - 1) ? g + 1 : g];
        end
      end
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_status   <= ST_MISS;
      out_position <= '0;
      out_tag      <= '0;
      out_score    <= '0;
      case (req_type)
        REQ_INSERT: begin
          if (ins_hit) begin
            out_status   <= ST_OK;
            out_position <= POS_W'(ins_idx);
          end
        end
        REQ_DELETE: begin
          out_status <= pos_ok ? ST_OK : ST_RANGE;
        end
        REQ_CLEAR: begin
          out_status <= ST_OK;
        end
        REQ_READ: begin
          if (pos_ok) begin
            out_status <= ST_OK;
            out_tag    <= tag_cell[rd_idx];
            out_score  <= score_cell[rd_idx];
          end else begin
            out_status <= ST_RANGE;
          end
        end
        REQ_FIND: begin
          if (find_hit) begin
            out_status   <= ST_OK;
            out_position <= POS_W'(find_idx);
            out_tag      <= tag_cell[rd_idx];
            out_score    <= score_cell[rd_idx];
          end
        end
        default: begin
          out_status <= ST_MISS;
        end
      endcase
    end
  end

endmodule

FILE: rtl/sorted_topk_insert_table.sv
// ----------------------------------------------------------------------------
// sorted_topk_insert_table
// Top-k table of (tag, score) entries kept in descending score order.
// ----------------------------------------------------------------------------
// The table holds LIST_SIZE entries in a row of registers, position 0 with
// the highest score. Each request word is captured at the edge that accepts
// it and its response word is loaded after a parallel compare of every
// entry, a priority resolve of the compare flags, and the apply step that
// shifts the row and loads the response register. That four-step sequencer
// takes no new request until the apply step of the last one is done; a
// stalled response holds the apply step until its register frees.
// Insert places the entry ahead of the first strictly lower score and drops
// the last entry; delete shifts later entries up and refills the last slot
// with the empty tag and score zero; clear empties every entry; read and
// find return a stored entry. Out-of-range positions answer status 2 and
// change nothing. Write empty_tag only while the block is idle; it affects
// entries emptied after the write, not entries already stored.
// ----------------------------------------------------------------------------
module sorted_topk_insert_table
  import stki_pkg::*;
#(
  parameter int LIST_SIZE = 16
) (
  input logic        clk,
  input logic        rst,
  stki_req_if.sink   req,
  stki_rsp_if.source rsp,
  stki_cfg_if.sink   cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // the empty-tag register is always ready to take a word
  assign cfg.ready = 1'b1;

  // sequence each request word through the datapath
  stki_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table row, compare, resolve and response register
  stki_datapath #(
    .LIST_SIZE (LIST_SIZE)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (req.req_type),
    .in_entry_tag   (req.entry_tag),
    .in_entry_score (req.entry_score),
    .in_position    (req.position),
    .cfg_valid      (cfg.valid),
    .cfg_empty_tag  (cfg.empty_tag),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_status     (rsp.status),
    .out_position   (rsp.out_position),
    .out_tag        (rsp.out_tag),
    .out_score      (rsp.out_score)
  );

endmodule
